### src/name_to_id_table_core_assert.svh
// assertion macros used by the name table datapath
`ifndef NAME_TO_ID_TABLE_CORE_ASSERT_SVH
`define NAME_TO_ID_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define NTID_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ntid same-cycle check failed");

// next-cycle implication
`define NTID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ntid next-cycle check failed");

`endif

### src/ntid_pkg.sv
package ntid_pkg;

    localparam int TABLE_ENTRIES_DEF = 128;
    localparam int NAME_BYTES_DEF    = 8;

    localparam int TASK_W = 7;
    localparam int KEY_W  = 64;

    localparam logic MODE_LOOKUP   = 1'b0;
    localparam logic MODE_REGISTER = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NOT_FOUND = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [TASK_W-1:0] task_number;
        logic [KEY_W-1:0]  name_key;
    } t_req;

    typedef struct packed {
        logic              status;
        logic [TASK_W-1:0] found_task;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_sts;

endpackage

### src/ntid_ctrl.sv
module ntid_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ntid_pkg::t_sts i_sts,
    output ntid_pkg::t_cmd o_cmd
);
    import ntid_pkg::*;

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_SCAN = 1'b1;

    logic [0:0] r_state;
    logic [0:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state == S_SCAN);

endmodule

### src/ntid_datapath.sv
module ntid_datapath #(
    parameter int TABLE_ENTRIES = ntid_pkg::TABLE_ENTRIES_DEF,
    parameter int NAME_BYTES    = ntid_pkg::NAME_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ntid_pkg::t_req i_req,
    input  ntid_pkg::t_cmd i_cmd,
    output ntid_pkg::t_sts o_sts,
    output logic           o_done,
    output ntid_pkg::t_rsp o_rsp
);
    import ntid_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * NAME_BYTES);

    logic [KEY_W-1:0]         mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;

    logic              r_mode;
    logic [TASK_W-1:0] r_task;
    logic [KEY_W-1:0]  r_key;
    logic [CNT_W-1:0]  r_addr;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic              r_cmp_vld;
    logic [KEY_W-1:0]  r_rd_data;
    logic              r_rd_valid;
    logic              r_done;
    t_rsp              r_rsp;

    logic rd_en;
    logic hit;
    logic last;
    logic task_ok;
    logic wr_en;

    assign rd_en   = i_cmd.scan && (r_addr < CNT_W'(TABLE_ENTRIES));
    // empty entries are masked by their valid bit and zero never matches
    assign hit     = r_cmp_vld && r_rd_valid && (r_rd_data != '0) && (r_rd_data == r_key);
    assign last    = r_cmp_vld && (r_cmp_idx == IDX_W'(TABLE_ENTRIES - 1));
    assign task_ok = (32'(r_task) < 32'(TABLE_ENTRIES));
    assign wr_en   = i_cmd.finish && (r_mode == MODE_REGISTER) && task_ok;

    assign o_sts.done = hit || last;

    // table storage, one read per scan cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_task[IDX_W-1:0]] <= r_key;
        end
        if (rd_en) begin
            r_rd_data  <= mem[r_addr[IDX_W-1:0]];
            r_rd_valid <= r_valid[r_addr[IDX_W-1:0]];
            r_cmp_idx  <= r_addr[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_addr    <= '0;
            r_cmp_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.load) begin
                r_addr    <= '0;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_cmp_vld <= rd_en;
                if (rd_en) begin
                    r_addr <= r_addr + CNT_W'(1);
                end
            end else if (i_cmd.finish) begin
                r_cmp_vld <= 1'b0;
            end
            // old holder is emptied first, the new entry wins when they coincide
            if (wr_en) begin
                if (hit) begin
                    r_valid[r_cmp_idx] <= 1'b0;
                end
                r_valid[r_task[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_req.mode;
            r_task <= i_req.task_number;
            r_key  <= i_req.name_key & KEY_MASK;
        end
        if (i_cmd.finish) begin
            r_rsp.status     <= ((r_mode == MODE_LOOKUP) && !hit) ? STATUS_NOT_FOUND
                                                                  : STATUS_OK;
            r_rsp.found_task <= ((r_mode == MODE_LOOKUP) && hit) ? TASK_W'(r_cmp_idx)
                                                                 : '0;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

`include "name_to_id_table_core_assert.svh"

    `NTID_ASSERT_IMPL(a_hit_key_nonzero, i_clk, i_rst_n, hit, r_key != '0)
    `NTID_ASSERT_IMPL(a_miss_no_task, i_clk, i_rst_n,
        r_done && (r_rsp.status == STATUS_NOT_FOUND), r_rsp.found_task == '0)
    `NTID_ASSERT_NEXT(a_finish_strobe, i_clk, i_rst_n, i_cmd.finish, r_done)
    `NTID_ASSERT_NEXT(a_load_rewinds, i_clk, i_rst_n, i_cmd.load, !r_cmp_vld && (r_addr == '0))

endmodule

### src/name_to_id_table_core.sv
// flow: a request taken at start && !busy is loaded, then the table is scanned from entry 0
// until the first match or the last entry; result and o_done strobe are then registered
// a new request is taken only when idle, after the single-port table scan
// (one entry read and compared per cycle); busy falls in the cycle the result is shown
// reset: synchronous active-low i_rst_n empties every entry at once, no clearing pass
// the result is shown for one cycle only; the receiver cannot stall
module name_to_id_table_core #(
    parameter int TABLE_ENTRIES = ntid_pkg::TABLE_ENTRIES_DEF,
    parameter int NAME_BYTES    = ntid_pkg::NAME_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ntid_pkg::t_req i_req,
    output logic           o_done,
    output ntid_pkg::t_rsp o_rsp
);
    import ntid_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ntid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ntid_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .NAME_BYTES    (NAME_BYTES)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

endmodule

### verif/tb_name_to_id_table_core.sv
module tb_name_to_id_table_core;
    import ntid_pkg::*;

    localparam int NUM_ENTRIES = TABLE_ENTRIES_DEF;
    localparam int KEY_BYTES   = NAME_BYTES_DEF;
    localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BYTES >= 8) ? {KEY_W{1'b1}} :
        ((64'd1 << (8 * KEY_BYTES)) - 64'd1);
    localparam int POOL_SIZE   = 32;
    localparam int STALL_LIMIT = 4000;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_done;
    t_rsp o_rsp;

    // predicted copy of the name table
    logic [KEY_W-1:0] name_keys [NUM_ENTRIES];
    t_rsp             pending_answers [$];
    logic [KEY_W-1:0] name_pool [POOL_SIZE];
    int               error_count;
    int               stall_cycles;
    bit               idling_on;

    name_to_id_table_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_rsp resolve_name_request(input t_req req);
        t_rsp             rsp;
        logic [KEY_W-1:0] key;
        int               hit;
        rsp.status     = STATUS_OK;
        rsp.found_task = '0;
        key = req.name_key & KEY_MASK;
        hit = -1;
        // scan downwards so the lowest matching entry wins
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
            if (name_keys[i] != '0 && name_keys[i] == key) hit = i;
        end
        if (req.mode == MODE_LOOKUP) begin
            if (hit >= 0) rsp.found_task = TASK_W'(hit);
            else rsp.status = STATUS_NOT_FOUND;
        end else if (int'(req.task_number) < NUM_ENTRIES) begin
            if (hit >= 0) name_keys[hit] = '0;
            name_keys[req.task_number] = key;
        end
        return rsp;
    endfunction

    function automatic logic [KEY_W-1:0] make_short_name();
        logic [KEY_W-1:0] key;
        int               len;
        key = '0;
        len = $urandom_range(1, 8);
        for (int b = 0; b < len; b++) key[8*b +: 8] = 8'($urandom_range(1, 255));
        return key;
    endfunction

    task automatic report_mismatch(input string field, input logic [KEY_W-1:0] got,
                                   input logic [KEY_W-1:0] want);
        $display("mismatch at %0t: %s got %0h, want %0h", $time, field, got, want);
        error_count++;
    endtask

    task automatic send_request(input logic mode, input logic [TASK_W-1:0] task_no,
                                input logic [KEY_W-1:0] key);
        t_req req;
        req.mode        = mode;
        req.task_number = task_no;
        req.name_key    = key;
        i_req <= req;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        pending_answers.push_back(resolve_name_request(req));
    endtask

    task automatic maybe_pause();
        if (idling_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_answers();
        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_cases();
        send_request(MODE_LOOKUP, 7'd0, 64'h0);                 // empty key on empty table
        send_request(MODE_LOOKUP, 7'd127, {KEY_W{1'b1}});
        send_request(MODE_REGISTER, 7'd127, {KEY_W{1'b1}});
        send_request(MODE_LOOKUP, 7'd0, {KEY_W{1'b1}});
        send_request(MODE_REGISTER, 7'd0, 64'h1);
        send_request(MODE_LOOKUP, 7'd127, 64'h1);
        send_request(MODE_REGISTER, 7'd5, 64'h1);               // moves the name to task 5
        send_request(MODE_LOOKUP, 7'd0, 64'h1);
        send_request(MODE_LOOKUP, 7'd0, 64'h0);
        send_request(MODE_REGISTER, 7'd5, 64'h0);               // empty key clears entry
        send_request(MODE_LOOKUP, 7'd0, 64'h1);
        send_request(MODE_REGISTER, 7'd127, 64'h8000_0000_0000_0000);
        send_request(MODE_LOOKUP, 7'd0, {KEY_W{1'b1}});
        send_request(MODE_LOOKUP, 7'd0, 64'h8000_0000_0000_0000);
        send_request(MODE_REGISTER, 7'd64, 64'h0000_0000_0073_7973);
        send_request(MODE_REGISTER, 7'd63, 64'h5A5A_A5A5_0F0F_F0F0);
        send_request(MODE_LOOKUP, 7'd1, 64'h0000_0000_0073_7973);
        send_request(MODE_LOOKUP, 7'd0, 64'h5A5A_A5A5_0F0F_F0F0);
        send_request(MODE_REGISTER, 7'd0, 64'h0);               // zero key at an empty entry
        send_request(MODE_REGISTER, 7'd63, 64'h0000_0000_0073_7973);
        send_request(MODE_LOOKUP, 7'd0, 64'h0000_0000_0073_7973);
        send_request(MODE_LOOKUP, 7'd0, 64'h5A5A_A5A5_0F0F_F0F0);
        send_request(MODE_LOOKUP, 7'd127, 64'h0);
    endtask

    task automatic test_full_table();
        int order [NUM_ENTRIES];
        int j;
        int tmp;
        for (int i = 0; i < NUM_ENTRIES; i++) order[i] = i;
        for (int i = NUM_ENTRIES - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        // distinct names: index in the top byte keeps them apart
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            send_request(MODE_REGISTER, TASK_W'(order[i]),
                         {8'(order[i] + 1), 56'($urandom) ^ {24'h0, 32'($urandom)}});
            maybe_pause();
        end
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            send_request(MODE_LOOKUP, TASK_W'($urandom), name_keys[order[i]]);
            maybe_pause();
        end
        send_request(MODE_LOOKUP, 7'd0, 64'h0);
        send_request(MODE_LOOKUP, 7'd0, {8'h0, 56'h1});          // full scan, no match
        for (int i = 0; i < 8; i++) begin
            send_request(MODE_REGISTER, TASK_W'($urandom), name_keys[order[i]]);
            send_request(MODE_LOOKUP, 7'd0, name_keys[order[i]]);
        end
    endtask

    task automatic random_request();
        int          pick;
        logic [KEY_W-1:0] key;
        pick = $urandom_range(0, 99);
        if (pick < 85) key = name_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (pick < 95) key = {$urandom, $urandom};
        else key = '0;
        send_request(($urandom_range(0, 99) < 40) ? MODE_REGISTER : MODE_LOOKUP,
                     TASK_W'($urandom), key);
    endtask

    task automatic test_random_traffic(input int count);
        for (int n = 0; n < count; n++) begin
            random_request();
            maybe_pause();
        end
    endtask

    task automatic test_drain_pauses();
        for (int r = 0; r < 4; r++) begin
            repeat (12) begin
                random_request();
                maybe_pause();
            end
            wait_for_answers();
        end
    endtask

    task automatic test_back_to_back();
        idling_on = 1'b0;
        test_random_traffic(120);
    endtask

    // results checked in arrival order
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected result", KEY_W'(o_rsp), '0);
            end else begin
                want = pending_answers.pop_front();
                if (o_rsp.status !== want.status)
                    report_mismatch("status", KEY_W'(o_rsp.status), KEY_W'(want.status));
                if (o_rsp.found_task !== want.found_task)
                    report_mismatch("found_task", KEY_W'(o_rsp.found_task),
                                    KEY_W'(want.found_task));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req        = '0;
        error_count  = 0;
        stall_cycles = 0;
        idling_on    = 1'b1;
        for (int i = 0; i < NUM_ENTRIES; i++) name_keys[i] = '0;
        for (int i = 0; i < POOL_SIZE; i++) name_pool[i] = make_short_name();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_full_table();
        test_random_traffic(850);
        test_drain_pauses();
        test_back_to_back();

        wait_for_answers();
        repeat (NUM_ENTRIES + 4) @(posedge i_clk);
        if (error_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
